// ===== rtl/core/lrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lrg_pkg: shared types and constants of the linear ramp generator
// Field widths, action codes, sequencer states and the micro-op table that
// orders the serial multiplies and divides of a step computation.
// ----------------------------------------------------------------------------
package lrg_pkg;

  localparam int unsigned ActionWidth  = 2;
  localparam int unsigned LevelWidth   = 16;
  localparam int unsigned TimeWidth    = 10;
  localparam int unsigned UsWidth      = 10;
  localparam int unsigned DivisorWidth = 20;

  localparam logic [UsWidth-1:0]      UsReset = 10'd20;
  localparam logic [DivisorWidth-1:0] Kilo    = 20'd1000;
  localparam logic [DivisorWidth-1:0] Mega    = 20'd1000000;

  typedef enum logic [ActionWidth-1:0] {
    ActTick    = 2'd0,
    ActSetDest = 2'd1,
    ActSetTime = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StMul,
    StDiv,
    StDone
  } state_e;

  // rounding order, chosen by the size of the distance
  typedef enum logic [1:0] {
    ModeBig,
    ModeMid,
    ModeSmall
  } mode_e;

  typedef enum logic [1:0] {
    OpMul,
    OpDiv,
    OpEnd
  } op_e;

  typedef enum logic [1:0] {
    SrcTime,
    SrcUs,
    SrcKilo,
    SrcMega
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e src;
  } uop_t;

  function automatic uop_t uop_lookup(mode_e mode, logic [2:0] idx);
    uop_t u;
    u = '{op: OpEnd, src: SrcTime};
    case (mode)
      ModeBig: begin
        // ((d / t) / 1000) * us
        case (idx)
          3'd0:    u = '{op: OpDiv, src: SrcTime};
          3'd1:    u = '{op: OpDiv, src: SrcKilo};
          3'd2:    u = '{op: OpMul, src: SrcUs};
          default: u = '{op: OpEnd, src: SrcTime};
        endcase
      end
      ModeMid: begin
        // ((d / t) * us) / 1000
        case (idx)
          3'd0:    u = '{op: OpDiv, src: SrcTime};
          3'd1:    u = '{op: OpMul, src: SrcUs};
          3'd2:    u = '{op: OpDiv, src: SrcKilo};
          default: u = '{op: OpEnd, src: SrcTime};
        endcase
      end
      ModeSmall: begin
        // (((d * 1000) / t) * us) / 1000000
        case (idx)
          3'd0:    u = '{op: OpMul, src: SrcKilo};
          3'd1:    u = '{op: OpDiv, src: SrcTime};
          3'd2:    u = '{op: OpMul, src: SrcUs};
          3'd3:    u = '{op: OpDiv, src: SrcMega};
          default: u = '{op: OpEnd, src: SrcTime};
        endcase
      end
      default: u = '{op: OpEnd, src: SrcTime};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/lrg_in_if.sv =====
// ----------------------------------------------------------------------------
// lrg_in_if: input channel of the linear ramp generator
// Valid/ready handshake carrying one action word.
// ----------------------------------------------------------------------------
interface lrg_in_if;
  logic                             valid;
  logic                             ready;
  logic [lrg_pkg::ActionWidth-1:0]  action;
  logic [lrg_pkg::LevelWidth-1:0]   dest_level;
  logic [lrg_pkg::TimeWidth-1:0]    ramp_time;

  modport source (output valid, action, dest_level, ramp_time, input ready);
  modport sink (input valid, action, dest_level, ramp_time, output ready);
endinterface

// ===== rtl/core/lrg_out_if.sv =====
// ----------------------------------------------------------------------------
// lrg_out_if: result channel of the linear ramp generator
// Valid/ready handshake carrying the current level word.
// ----------------------------------------------------------------------------
interface lrg_out_if;
  logic                           valid;
  logic                           ready;
  logic [lrg_pkg::LevelWidth-1:0] level;
  logic                           ramp_active;

  modport source (output valid, level, ramp_active, input ready);
  modport sink (input valid, level, ramp_active, output ready);
endinterface

// ===== rtl/core/linear_ramp_generator_unit.sv =====
// ----------------------------------------------------------------------------
// linear_ramp_generator_unit: fixed-point linear ramp (slew) generator
// Holds a position, a destination and a signed per-tick step; set words
// recompute the step with a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// One word in, one word out. A tick, an unused action, a set word that leaves
// its value unchanged and a set word with a ramp time of zero go straight
// from idle to the done state. A set word that needs a step computation runs
// through the shared bit-serial divider (one quotient bit per cycle over
// W = FractionBits + 22 bits) and shift-add multiplier: two divides and one
// multiply for distances of 4 levels or more, two of each below that.
// A new word is taken once the previous one has been handed to the result
// register, which may still be waiting for the sink.
// ----------------------------------------------------------------------------
module linear_ramp_generator_unit #(
  parameter int unsigned FractionBits = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lrg_pkg::UsWidth-1:0]  cfg_wdata_i,
  lrg_in_if.sink                       in_i,
  lrg_out_if.source                    out_o
);

  localparam int unsigned PosW  = lrg_pkg::LevelWidth + FractionBits;
  localparam int unsigned StepW = FractionBits + 18;
  localparam int unsigned DiffW = PosW + 2;
  localparam int unsigned MagW  = FractionBits + 17;
  localparam int unsigned WorkW = FractionBits + 22;
  localparam int unsigned SumW  = PosW + 3;
  localparam int unsigned CntW  = $clog2(WorkW + 1);
  localparam int unsigned DvW   = lrg_pkg::DivisorWidth;

  localparam logic [MagW-1:0] BigLim   = MagW'(4000) << FractionBits;
  localparam logic [MagW-1:0] SmallLim = MagW'(4) << FractionBits;

  // state
  lrg_pkg::state_e               state_q, state_d;
  logic [PosW-1:0]               position_q, position_d;
  logic [PosW-1:0]               target_q, target_d;
  logic [StepW-1:0]              step_q, step_d;
  logic [lrg_pkg::TimeWidth-1:0] dur_q, dur_d;
  logic [lrg_pkg::UsWidth-1:0]   us_q;
  lrg_pkg::mode_e                mode_q, mode_d;
  logic [2:0]                    idx_q, idx_d;
  logic                          neg_q, neg_d;
  logic                          snap_q, snap_d;
  logic [CntW-1:0]               cnt_q, cnt_d;

  // serial datapath
  logic [WorkW-1:0] work_q, work_d;
  logic [WorkW-1:0] acc_q, acc_d;
  logic [DvW-1:0]   rem_q, rem_d;
  logic [DvW-1:0]   opnd_q, opnd_d;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic [lrg_pkg::LevelWidth-1:0]  level_q;
  logic                            active_q;

  logic                  accept;
  logic                  out_load;
  lrg_pkg::action_e      act;
  logic [PosW-1:0]       nd;
  logic                  set_dest, set_time, start_calc, need_div;
  logic [PosW-1:0]       tgt_new;
  logic [lrg_pkg::TimeWidth-1:0] dur_new;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]      diff_abs;
  logic [MagW-1:0]       mag;
  lrg_pkg::mode_e        mode_new;
  lrg_pkg::uop_t         uop;
  logic [DvW-1:0]        src_val;
  logic                  cnt_last;
  logic [WorkW-1:0]      acc_sum;
  logic [DvW:0]          rem_shift;
  logic                  rem_ge;
  logic [DvW:0]          rem_sub;
  logic [StepW-1:0]      mag_fin, step_fin;
  logic signed [SumW-1:0] pos_sum, tgt_ext;
  logic                  step_pos, step_neg, clamp;

  // ---------------------------------------------------------------- decode
  assign accept     = in_i.valid & in_i.ready;
  assign act        = lrg_pkg::action_e'(in_i.action);
  assign nd         = {in_i.dest_level, FractionBits'(0)};
  assign set_dest   = (act == lrg_pkg::ActSetDest) && (nd != target_q);
  assign set_time   = (act == lrg_pkg::ActSetTime) && (in_i.ramp_time != dur_q);
  assign start_calc = set_dest || set_time;
  assign tgt_new    = set_dest ? nd : target_q;
  assign dur_new    = set_time ? in_i.ramp_time : dur_q;
  assign need_div   = start_calc && (dur_new != '0);

  assign diff     = $signed({2'b00, tgt_new}) - $signed({2'b00, position_q});
  assign diff_abs = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign mag      = diff_abs[MagW-1:0];

  always_comb begin
    if (mag > BigLim) begin
      mode_new = lrg_pkg::ModeBig;
    end else if (mag < SmallLim) begin
      mode_new = lrg_pkg::ModeSmall;
    end else begin
      mode_new = lrg_pkg::ModeMid;
    end
  end

  assign uop = lrg_pkg::uop_lookup(mode_q, idx_q);

  always_comb begin
    case (uop.src)
      lrg_pkg::SrcTime: src_val = DvW'(dur_q);
      lrg_pkg::SrcUs:   src_val = DvW'(us_q);
      lrg_pkg::SrcKilo: src_val = lrg_pkg::Kilo;
      lrg_pkg::SrcMega: src_val = lrg_pkg::Mega;
      default:          src_val = lrg_pkg::Kilo;
    endcase
  end

  assign cnt_last = (cnt_q == CntW'(1));

  // shift-add multiplier: work holds the shifting multiplicand
  assign acc_sum = opnd_q[0] ? (acc_q + work_q) : acc_q;

  // restoring divider: work shifts the dividend out and the quotient in
  assign rem_shift = {rem_q, work_q[WorkW-1]};
  assign rem_ge    = rem_shift >= {1'b0, opnd_q};
  assign rem_sub   = rem_shift - {1'b0, opnd_q};

  assign mag_fin  = work_q[StepW-1:0];
  assign step_fin = neg_q ? StepW'(-mag_fin) : mag_fin;

  // tick
  assign pos_sum  = $signed({3'b000, position_q}) + $signed({step_q[StepW-1], step_q});
  assign tgt_ext  = $signed({3'b000, target_q});
  assign step_neg = step_q[StepW-1];
  assign step_pos = !step_q[StepW-1] && (step_q != '0);
  assign clamp    = (step_pos && (pos_sum >= tgt_ext)) || (step_neg && (pos_sum <= tgt_ext));

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrg_pkg::StIdle: begin
        if (accept) begin
          state_d = need_div ? lrg_pkg::StSetup : lrg_pkg::StDone;
        end
      end
      lrg_pkg::StSetup: begin
        case (uop.op)
          lrg_pkg::OpMul: state_d = lrg_pkg::StMul;
          lrg_pkg::OpDiv: state_d = lrg_pkg::StDiv;
          default:        state_d = lrg_pkg::StDone;
        endcase
      end
      lrg_pkg::StMul, lrg_pkg::StDiv: begin
        if (cnt_last) begin
          state_d = lrg_pkg::StSetup;
        end
      end
      lrg_pkg::StDone: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = lrg_pkg::StIdle;
        end
      end
      default: state_d = lrg_pkg::StIdle;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    in_i.ready = (state_q == lrg_pkg::StIdle);
    out_load   = (state_q == lrg_pkg::StDone) && (!out_valid_q || out_o.ready);
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.level       = level_q;
  assign out_o.ramp_active = active_q;

  // -------------------------------------------------------------- datapath
  always_comb begin
    position_d = position_q;
    target_d   = target_q;
    step_d     = step_q;
    dur_d      = dur_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    neg_d      = neg_q;
    snap_d     = snap_q;
    cnt_d      = cnt_q;
    work_d     = work_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    opnd_d     = opnd_q;
    case (state_q)
      lrg_pkg::StIdle: begin
        if (accept) begin
          if (act == lrg_pkg::ActTick && step_q != '0) begin
            if (clamp) begin
              position_d = target_q;
              step_d     = '0;
            end else begin
              position_d = pos_sum[PosW-1:0];
            end
          end
          if (set_dest) begin
            target_d = nd;
          end
          if (set_time) begin
            dur_d = in_i.ramp_time;
          end
          snap_d = set_dest;
          if (start_calc) begin
            if (dur_new == '0) begin
              // zero ramp time: the next tick jumps
              step_d = StepW'(diff);
            end else begin
              neg_d  = diff[DiffW-1];
              work_d = WorkW'(mag);
              mode_d = mode_new;
              idx_d  = '0;
            end
          end
        end
      end
      lrg_pkg::StSetup: begin
        case (uop.op)
          lrg_pkg::OpMul: begin
            opnd_d = src_val;
            acc_d  = '0;
            cnt_d  = CntW'(lrg_pkg::UsWidth);
          end
          lrg_pkg::OpDiv: begin
            opnd_d = src_val;
            rem_d  = '0;
            cnt_d  = CntW'(WorkW);
          end
          default: begin
            step_d = step_fin;
            // after a new destination, a step that rounds to nothing snaps straight to it
            if (snap_q && step_fin == '0 && target_q != position_q) begin
              position_d = target_q;
            end
          end
        endcase
      end
      lrg_pkg::StMul: begin
        acc_d  = acc_sum;
        opnd_d = opnd_q >> 1;
        work_d = work_q << 1;
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_last) begin
          work_d = acc_sum;
          idx_d  = idx_q + 3'd1;
        end
      end
      lrg_pkg::StDiv: begin
        rem_d  = rem_ge ? rem_sub[DvW-1:0] : rem_shift[DvW-1:0];
        work_d = {work_q[WorkW-2:0], rem_ge};
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_last) begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrg_pkg::StIdle;
      position_q  <= '0;
      target_q    <= '0;
      step_q      <= '0;
      dur_q       <= '0;
      us_q        <= lrg_pkg::UsReset;
      mode_q      <= lrg_pkg::ModeMid;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      snap_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      position_q  <= position_d;
      target_q    <= target_d;
      step_q      <= step_d;
      dur_q       <= dur_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      snap_q      <= snap_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        us_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    opnd_q <= opnd_d;
    if (out_load) begin
      level_q  <= position_q[PosW-1:FractionBits];
      active_q <= (step_q != '0);
    end
  end

endmodule
